@@ sv/tridiagonal_thomas_solver_macros.svh @@
// Assertion macros for the tridiagonal solver.
// Used by sv/tridiagonal_thomas_solver.sv; expects clk and rst_n in scope.
`ifndef TRIDIAGONAL_THOMAS_SOLVER_MACROS_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_MACROS_SVH
`ifndef SYNTHESIS
`define TTS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tridiagonal solver check failed");
`define TTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tridiagonal solver check failed");
`else
`define TTS_ASSERT_SAME(label, ante, cons)
`define TTS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ sv/tts_pkg.sv @@
// Types, constants and saturation helper for the tridiagonal solver.
// No dependencies.
package tts_pkg;

    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 48;
    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] sub_diag;
        logic signed [31:0] main_diag;
        logic signed [31:0] super_diag;
        logic signed [31:0] rhs_value;
        logic               last_row;
    } row_in_t;

    typedef struct packed {
        logic signed [31:0] solution;
        logic [3:0]         row_index;
        logic               last_out;
        logic               solve_error;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_RD,
        S_MUL_B,
        S_DEN,
        S_MUL_G,
        S_NUMG,
        S_DIVINIT_B,
        S_DIV_B,
        S_DIVINIT_G,
        S_DIV_G,
        S_WRITE,
        S_BS_RD,
        S_BS_DAT,
        S_BS_MUL,
        S_BS_ADD
    } state_t;

    // S_EMIT kept apart: the enum above is full at 4 bits
    typedef enum logic {
        EMIT_OFF,
        EMIT_ON
    } emit_t;

    function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
        logic signed [31:0] r;
        if (v > 49'sd2147483647)
            r = Q_MAX;
        else if (v < -49'sd2147483648)
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ sv/tridiagonal_thomas_solver.sv @@
// Tridiagonal solver top level: forward sweep, coefficient memories, back substitution.
// Depends on tts_pkg and tridiagonal_thomas_solver_macros.svh.
`include "tridiagonal_thomas_solver_macros.svh"

// Thomas-algorithm solver, signed Q16.16. One row is transferred per start pulse
// (start high while busy low). Row zero runs two restoring 48-step divides; later rows
// run two bit-serial 32-step multiplies first. Multiplies share one shift-add datapath,
// divides one shift-subtract datapath. On the row marked last the unknowns are emitted
// last first, one result_valid pulse each, one serial multiply per unknown after the
// first. The receiver cannot stall; each result is shown for one cycle.
// Rows beyond MAX_ROWS are dropped and flag solve_error. No clearing pass after reset.
module tridiagonal_thomas_solver #(
    parameter int MAX_ROWS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tts_pkg::row_in_t row_in,
    output logic             result_valid,
    output tts_pkg::result_t result
);
    import tts_pkg::*;

    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);

    state_t state_reg, state_next;
    emit_t  emit_reg, emit_next;

    logic [CW-1:0] row_cnt_reg;
    logic          err_reg;
    logic          strobe_reg;
    logic [5:0]    cnt_reg;

    row_in_t            in_reg;
    logic signed [31:0] den_reg, numg_reg, beta_new_reg, x_reg;
    logic signed [31:0] rb_reg, rg_reg;
    logic [32:0]        m_hi_reg;
    logic [31:0]        m_lo_reg, m_cand_reg;
    logic [47:0]        dvd_reg;
    logic [31:0]        r_reg, dvs_reg;
    logic               dz_reg, nz_reg, nneg_reg, qneg_reg;
    logic [AW-1:0]      i_reg;
    logic               first_reg;
    result_t            out_reg;

    logic signed [31:0] beta_mem  [MAX_ROWS];
    logic signed [31:0] gamma_mem [MAX_ROWS];

    logic          full, mem_we, mul_done, div_done;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [CW-1:0] cnt_m1;

    // serial multiply step
    logic [33:0]        m_add, m_sum;
    logic [63:0]        prod;
    logic signed [48:0] p_plus_b, d_minus_p, p_plus_g;

    // serial divide step
    logic [32:0]        r_sh;
    logic               q_bit;
    logic signed [31:0] div_res;
    logic [31:0]        q_neg32;

    // divider operand set-up
    logic [31:0] c_mag, g_mag, den_mag;

    assign full     = row_cnt_reg >= CW'(MAX_ROWS);
    assign cnt_m1   = row_cnt_reg - CW'(1);
    assign wr_addr  = AW'(row_cnt_reg);
    assign mul_done = cnt_reg == 6'(MUL_STEPS - 1);
    assign div_done = cnt_reg == 6'(DIV_STEPS - 1);

    assign m_add = !m_lo_reg[0] ? 34'd0 :
                   mul_done ? -{{2{m_cand_reg[31]}}, m_cand_reg} :
                   {{2{m_cand_reg[31]}}, m_cand_reg};
    assign m_sum = {m_hi_reg[32], m_hi_reg} + m_add;
    assign prod  = {m_hi_reg[31:0], m_lo_reg};
    assign p_plus_b  = $signed({prod[63], prod[63:16]}) + 49'(in_reg.main_diag);
    assign d_minus_p = 49'(in_reg.rhs_value) - $signed({prod[63], prod[63:16]});
    assign p_plus_g  = $signed({prod[63], prod[63:16]}) + 49'(rg_reg);

    assign r_sh  = {r_reg, dvd_reg[47]};
    assign q_bit = r_sh >= {1'b0, dvs_reg};

    assign c_mag   = in_reg.super_diag[31] ? 32'(-in_reg.super_diag) : in_reg.super_diag;
    assign g_mag   = numg_reg[31] ? 32'(-numg_reg) : numg_reg;
    assign den_mag = den_reg[31] ? 32'(-den_reg) : den_reg;
    assign q_neg32 = 32'd0 - dvd_reg[31:0];

    always_comb
    begin
        if (dz_reg)
            div_res = nz_reg ? 32'sd0 : (nneg_reg ? Q_MIN : Q_MAX);
        else if (qneg_reg)
            div_res = (dvd_reg[47:32] != 16'd0 || (dvd_reg[31] && dvd_reg[30:0] != 31'd0))
                      ? Q_MIN : $signed(q_neg32);
        else
            div_res = (dvd_reg[47:31] != 17'd0) ? Q_MAX : $signed(dvd_reg[31:0]);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        emit_next  = EMIT_OFF;
        case (state_reg)
            S_IDLE:
                if (emit_reg == EMIT_ON && i_reg != '0)
                    state_next = S_BS_RD;
                else if (emit_reg == EMIT_OFF && start)
                    state_next = S_LOAD;
            S_LOAD:
                if (full)
                    state_next = in_reg.last_row ? S_BS_RD : S_IDLE;
                else if (row_cnt_reg == '0)
                    state_next = S_DIVINIT_B;
                else
                    state_next = S_RD;
            S_RD:        state_next = S_MUL_B;
            S_MUL_B:     if (mul_done) state_next = S_DEN;
            S_DEN:       state_next = S_MUL_G;
            S_MUL_G:     if (mul_done) state_next = S_NUMG;
            S_NUMG:      state_next = S_DIVINIT_B;
            S_DIVINIT_B: state_next = S_DIV_B;
            S_DIV_B:     if (div_done) state_next = S_DIVINIT_G;
            S_DIVINIT_G: state_next = S_DIV_G;
            S_DIV_G:     if (div_done) state_next = S_WRITE;
            S_WRITE:     state_next = in_reg.last_row ? S_BS_RD : S_IDLE;
            S_BS_RD:     state_next = S_BS_DAT;
            S_BS_DAT:
                if (first_reg)
                begin
                    state_next = S_IDLE;
                    emit_next  = EMIT_ON;
                end
                else
                    state_next = S_BS_MUL;
            S_BS_MUL:    if (mul_done) state_next = S_BS_ADD;
            S_BS_ADD:
            begin
                state_next = S_IDLE;
                emit_next  = EMIT_ON;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        busy    = state_reg != S_IDLE || emit_reg == EMIT_ON;
        mem_we  = state_reg == S_WRITE;
        case (state_reg)
            S_BS_RD, S_BS_DAT, S_BS_MUL, S_BS_ADD: rd_addr = i_reg;
            default:                                rd_addr = AW'(cnt_m1);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            emit_reg    <= EMIT_OFF;
            row_cnt_reg <= '0;
            err_reg     <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            emit_reg   <= emit_next;
            strobe_reg <= emit_reg == EMIT_ON;
            if (state_reg == S_LOAD && full)
                err_reg <= 1'b1;
            if ((state_reg == S_DIVINIT_B || state_reg == S_DIVINIT_G) && den_reg == 32'sd0)
                err_reg <= 1'b1;
            if (state_reg == S_WRITE)
                row_cnt_reg <= row_cnt_reg + CW'(1);
            if (emit_reg == EMIT_ON && i_reg == '0)
            begin
                row_cnt_reg <= '0;
                err_reg     <= 1'b0;
            end
        end
    end

    // coefficient memories, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            beta_mem[wr_addr]  <= beta_new_reg;
            gamma_mem[wr_addr] <= div_res;
        end
        rb_reg <= beta_mem[rd_addr];
        rg_reg <= gamma_mem[rd_addr];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (emit_reg == EMIT_ON)
        begin
            out_reg.solution    <= x_reg;
            out_reg.row_index   <= 4'(i_reg);
            out_reg.last_out    <= i_reg == '0;
            out_reg.solve_error <= err_reg;
            if (i_reg != '0)
            begin
                i_reg     <= i_reg - AW'(1);
                first_reg <= 1'b0;
            end
        end
        case (state_reg)
            S_IDLE:
                if (emit_reg == EMIT_OFF && start)
                    in_reg <= row_in;
            S_LOAD:
            begin
                den_reg   <= in_reg.main_diag;
                numg_reg  <= in_reg.rhs_value;
                i_reg     <= AW'(cnt_m1);
                first_reg <= 1'b1;
            end
            S_RD:
            begin
                m_cand_reg <= in_reg.sub_diag;
                m_lo_reg   <= rb_reg;
                m_hi_reg   <= '0;
                cnt_reg    <= '0;
            end
            S_DEN:
            begin
                den_reg    <= sat49(p_plus_b);
                m_lo_reg   <= rg_reg;
                m_hi_reg   <= '0;
                cnt_reg    <= '0;
            end
            S_NUMG:
                numg_reg <= sat49(d_minus_p);
            S_MUL_B, S_MUL_G, S_BS_MUL:
            begin
                m_hi_reg <= m_sum[33:1];
                m_lo_reg <= {m_sum[0], m_lo_reg[31:1]};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            S_DIVINIT_B:
            begin
                dvd_reg  <= {c_mag, 16'd0};
                r_reg    <= '0;
                dvs_reg  <= den_mag;
                dz_reg   <= den_reg == 32'sd0;
                nz_reg   <= in_reg.super_diag == 32'sd0;
                nneg_reg <= !in_reg.super_diag[31] && in_reg.super_diag != 32'sd0;
                qneg_reg <= (!in_reg.super_diag[31]) ^ den_reg[31];
                cnt_reg  <= '0;
            end
            S_DIVINIT_G:
            begin
                beta_new_reg <= div_res;
                dvd_reg  <= {g_mag, 16'd0};
                r_reg    <= '0;
                dvs_reg  <= den_mag;
                dz_reg   <= den_reg == 32'sd0;
                nz_reg   <= numg_reg == 32'sd0;
                nneg_reg <= numg_reg[31];
                qneg_reg <= numg_reg[31] ^ den_reg[31];
                cnt_reg  <= '0;
            end
            S_DIV_B, S_DIV_G:
            begin
                r_reg   <= q_bit ? 32'(r_sh - {1'b0, dvs_reg}) : r_sh[31:0];
                dvd_reg <= {dvd_reg[46:0], q_bit};
                cnt_reg <= cnt_reg + 6'd1;
            end
            S_WRITE:
            begin
                i_reg     <= wr_addr;
                first_reg <= 1'b1;
            end
            S_BS_DAT:
            begin
                if (first_reg)
                    x_reg <= rg_reg;
                m_cand_reg <= rb_reg;
                m_lo_reg   <= x_reg;
                m_hi_reg   <= '0;
                cnt_reg    <= '0;
            end
            S_BS_ADD:
                x_reg <= sat49(p_plus_g);
            default:
            begin
            end
        endcase
    end

    assign result_valid = strobe_reg;
    assign result       = out_reg;

    `TTS_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `TTS_ASSERT_NEXT(a_strobe_gap, result_valid, !result_valid)
    `TTS_ASSERT_SAME(a_cnt_range, 1'b1, row_cnt_reg <= CW'(MAX_ROWS))
    `TTS_ASSERT_NEXT(a_last_clears, result_valid && result.last_out, row_cnt_reg == '0)

endmodule

@@ verif/tts_result_checker.sv @@
// Checker for the tridiagonal solver: watches row and result transfers, predicts unknowns.
// Depends on tts_pkg (row_in_t, result_t, Q_MAX, Q_MIN).
module tts_result_checker #(
    parameter int MAX_ROWS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  tts_pkg::row_in_t row_in,
    input  logic             result_valid,
    input  tts_pkg::result_t result,
    output int               fail_count,
    output int               pending,
    output int               checked
);
    import tts_pkg::*;

    result_t            unknowns_q[$];
    logic signed [31:0] beta_mem [MAX_ROWS];
    logic signed [31:0] gamma_mem[MAX_ROWS];
    int unsigned        rows_held;
    bit                 fault_seen;

    function automatic logic signed [31:0] clamp_q(input longint v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = Q_MAX;
        else if (v < -64'sd2147483648)
            r = Q_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

    // arithmetic shift of the exact product rounds toward minus infinity
    function automatic longint prod_q(input logic signed [31:0] x,
                                      input logic signed [31:0] y);
        longint p;
        p = longint'(x) * longint'(y);
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] quot_q(input longint num,
                                                  input logic signed [31:0] den);
        logic signed [31:0] r;
        if (den == 0)
        begin
            fault_seen = 1'b1;
            r = (num > 0) ? Q_MAX : (num < 0) ? Q_MIN : 32'sd0;
        end
        else
            r = clamp_q((num * 64'sd65536) / longint'(den));
        return r;
    endfunction

    task automatic sweep_row(input row_in_t r);
        logic signed [31:0] den;
        logic signed [31:0] num_g;
        logic signed [31:0] x;
        result_t            e;
        int                 i;
        if (rows_held >= MAX_ROWS)
            fault_seen = 1'b1;
        else
        begin
            if (rows_held == 0)
            begin
                den   = r.main_diag;
                num_g = r.rhs_value;
            end
            else
            begin
                den   = clamp_q(prod_q(r.sub_diag, beta_mem[rows_held-1])
                                + longint'(r.main_diag));
                num_g = clamp_q(longint'(r.rhs_value)
                                - prod_q(r.sub_diag, gamma_mem[rows_held-1]));
            end
            beta_mem[rows_held]  = quot_q(-longint'(r.super_diag), den);
            gamma_mem[rows_held] = quot_q(longint'(num_g), den);
            rows_held++;
        end
        if (r.last_row)
        begin
            x = gamma_mem[rows_held-1];
            for (i = rows_held - 1; i >= 0; i--)
            begin
                if (i < rows_held - 1)
                    x = clamp_q(prod_q(beta_mem[i], x) + longint'(gamma_mem[i]));
                e.solution    = x;
                e.row_index   = i[3:0];
                e.last_out    = (i == 0);
                e.solve_error = fault_seen;
                unknowns_q    = {unknowns_q, e};
            end
            rows_held  = 0;
            fault_seen = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            unknowns_q.delete();
            rows_held  = 0;
            fault_seen = 1'b0;
            fail_count = 0;
            checked    = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (unknowns_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, result);
                end
                else
                begin
                    e = unknowns_q.pop_front();
                    checked++;
                    if (result.solution !== e.solution || result.row_index !== e.row_index ||
                        result.last_out !== e.last_out || result.solve_error !== e.solve_error)
                    begin
                        fail_count++;
                        $display({"%0t: mismatch, expected x=%h idx=%0d last=%b err=%b,",
                                  " actual x=%h idx=%0d last=%b err=%b"},
                                 $time, e.solution, e.row_index, e.last_out, e.solve_error,
                                 result.solution, result.row_index, result.last_out,
                                 result.solve_error);
                    end
                end
            end
            if (start && !busy)
                sweep_row(row_in);
        end
        pending = unknowns_q.size();
    end

    final
    begin
        if (unknowns_q.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, unknowns_q.size());
    end
endmodule

@@ verif/tb_top.sv @@
// Testbench top for the tridiagonal solver: clock, reset, row stimulus and verdict.
// Depends on tts_pkg, tridiagonal_thomas_solver and tts_result_checker.
module tb_top;
    import tts_pkg::*;

    localparam int MAX_ROWS_TB = 16;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    row_in_t row_in;
    logic    result_valid;
    result_t result;
    int      fail_count;
    int      pending;
    int      checked;
    int      rows_sent;
    int      systems_sent;

    tridiagonal_thomas_solver u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .row_in(row_in), .result_valid(result_valid), .result(result)
    );

    tts_result_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .row_in(row_in),
        .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending(pending), .checked(checked)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // drive one row; start stays high across back-to-back transfers
    task automatic send_row(input row_in_t r, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        row_in <= r;
        do @(posedge clk); while (busy);
        rows_sent++;
    endtask

    // stop sending until every predicted unknown has been seen
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_word();
        return $urandom();
    endfunction

    function automatic logic signed [31:0] rand_small(input int unsigned mag);
        logic signed [31:0] v;
        v = $urandom_range(mag << 16);
        return $urandom_range(1) ? -v : v;
    endfunction

    // well-conditioned rows are diagonally dominant; the rest are raw noise
    function automatic row_in_t make_row(input bit noisy, input bit last);
        row_in_t r;
        if (noisy)
        begin
            r.sub_diag   = rand_word();
            r.main_diag  = ($urandom_range(9) == 0) ? 32'sd0 : rand_word();
            r.super_diag = rand_word();
            r.rhs_value  = rand_word();
        end
        else
        begin
            r.sub_diag   = rand_small(1);
            r.super_diag = rand_small(1);
            r.main_diag  = 32'sd262144 + $urandom_range(32'h0004_0000);
            if ($urandom_range(1))
                r.main_diag = -r.main_diag;
            r.rhs_value  = rand_small(200);
        end
        r.last_row = last;
        return r;
    endfunction

    task automatic send_system(input int n_rows, input bit noisy, input bit no_gaps);
        int k;
        for (k = 0; k < n_rows; k++)
            send_row(make_row(noisy && $urandom_range(1), k == n_rows - 1),
                     no_gaps ? 0 : $urandom_range(18));
        systems_sent++;
    endtask

    initial
    begin
        row_in_t r;
        int      n;
        start        = 1'b0;
        row_in       = '0;
        rows_sent    = 0;
        systems_sent = 0;
        rst_n        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-row systems at the extremes, zero divisors with each numerator sign
        r = '{Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1};   send_row(r, 0);
        r = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1};   send_row(r, 3);
        r = '{32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 1'b1};   send_row(r, 0);
        r = '{32'sd0, 32'sd0, -32'sd65536, -32'sd65536, 1'b1}; send_row(r, 0);
        r = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1};           send_row(r, 1);
        r = '{32'sd1, 32'sd1, Q_MAX, Q_MIN, 1'b1};             send_row(r, 0);
        r = '{-32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b1};       send_row(r, 0);
        // two rows where the second divisor cancels to zero
        r = '{32'sd0, 32'sd65536, -32'sd65536, 32'sd65536, 1'b0};   send_row(r, 0);
        r = '{32'sd65536, -32'sd65536, 32'sd0, 32'sd131072, 1'b1}; send_row(r, 0);
        systems_sent += 8;
        // full depth, then overflow on a plain row and on the last row
        send_system(MAX_ROWS_TB, 1'b0, 1'b1);
        send_system(MAX_ROWS_TB + 2, 1'b0, 1'b0);

        drain_results();

        while (rows_sent < 130)
        begin
            n = ($urandom_range(7) == 0) ? $urandom_range(MAX_ROWS_TB + 2, MAX_ROWS_TB)
                                         : $urandom_range(6, 1);
            send_system(n, $urandom_range(3) == 0, $urandom_range(4) == 0);
            if ($urandom_range(5) == 0)
                drain_results();
        end

        drain_results();
        repeat (300) @(posedge clk);
        $display("covered %0d rows in %0d systems, %0d unknowns checked",
                 rows_sent, systems_sent, checked);
        $display("incl. zero divisors, saturation and rows past the storage depth");
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end
endmodule
